// ----- hw/rtl/lpgb_pkg.sv -----
// ----------------------------------------------------------------------------
// lpgb_pkg
// Shared constants, register codes and the arctangent table for polar binning.
// ----------------------------------------------------------------------------
package lpgb_pkg;

  localparam int unsigned COORD_BITS_DEF = 20;
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF = 10;

  localparam int unsigned CORDIC_STEPS   = 30;
  localparam int unsigned CORDIC_WIDTH   = 64;
  localparam int unsigned ACC_BITS       = 32;
  localparam int unsigned RANGE_OUT_BITS = 20;
  localparam int unsigned LIMIT_BITS     = 20;
  localparam int unsigned COUNT_BITS     = 11;
  localparam int unsigned QUOT_BITS      = COUNT_BITS;
  localparam int unsigned NUM_BITS       = LIMIT_BITS + COUNT_BITS;
  localparam int unsigned CFG_ADDR_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS  = LIMIT_BITS;

  localparam logic [LIMIT_BITS-1:0] RANGE_MIN_RST    = 20'd3000;
  localparam logic [LIMIT_BITS-1:0] RANGE_MAX_RST    = 20'd100000;
  localparam logic [COUNT_BITS-1:0] BIN_COUNT_RST    = 11'd120;
  localparam logic [COUNT_BITS-1:0] SECTOR_COUNT_RST = 11'd360;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CfgRangeMin    = 3'd0,
    CfgRangeMax    = 3'd1,
    CfgBinCount    = 3'd2,
    CfgSectorCount = 3'd3
  } cfg_reg_e;

  // atan(2^-i) in units of 2^-32 turn, truncated
  function automatic logic [ACC_BITS-1:0] atan_entry(int unsigned i);
    logic [ACC_BITS-1:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2E;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      24: r = 32'h00000028;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000002;
      29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/lpgb_delay.sv -----
// ----------------------------------------------------------------------------
// lpgb_delay
// Stallable register chain that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module lpgb_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  if (Depth == 0) begin : g_wire
    assign q_o = d_i;
  end else begin : g_regs
    logic [Width-1:0] tap_q [Depth];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[0] <= d_i;
        for (int unsigned i = 1; i < Depth; i++) begin
          tap_q[i] <= tap_q[i-1];
        end
      end
    end
    assign q_o = tap_q[Depth-1];
  end

endmodule

// ----- hw/rtl/lpgb_isqrt.sv -----
// ----------------------------------------------------------------------------
// lpgb_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lpgb_isqrt #(
  parameter int unsigned RootBits = 20
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*RootBits-1:0] rad_i,
  output logic [RootBits-1:0]   root_o
);

  localparam int unsigned RadBits = 2 * RootBits;
  localparam int unsigned RemBits = RootBits + 3;

  logic [RadBits-1:0]  rad_q  [1:RootBits];
  logic [RemBits-1:0]  rem_q  [1:RootBits];
  logic [RootBits-1:0] root_q [1:RootBits];

  for (genvar k = 0; k < RootBits; k++) begin : g_stage
    logic [RadBits-1:0]  rad_in;
    logic [RemBits-1:0]  rem_in;
    logic [RootBits-1:0] root_in;
    logic [RemBits-1:0]  rem_sh;
    logic [RemBits-1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[RemBits-3:0], rad_in[RadBits-1 -: 2]};
    assign trial  = RemBits'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_q[k+1]  <= rem_sh - trial;
          root_q[k+1] <= {root_in[RootBits-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_sh;
          root_q[k+1] <= {root_in[RootBits-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RootBits];

endmodule

// ----- hw/rtl/lpgb_cordic.sv -----
// ----------------------------------------------------------------------------
// lpgb_cordic
// Pipelined vectoring CORDIC giving the turn of (-x, -y), one step per stage.
// ----------------------------------------------------------------------------
module lpgb_cordic #(
  parameter int unsigned CoordBits = lpgb_pkg::COORD_BITS_DEF,
  parameter int unsigned AngleBits = lpgb_pkg::ANGLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  output logic [AngleBits-1:0] turn_o
);

  localparam int unsigned Steps = lpgb_pkg::CORDIC_STEPS;
  localparam int unsigned W     = lpgb_pkg::CORDIC_WIDTH;
  localparam int unsigned AccW  = lpgb_pkg::ACC_BITS;
  localparam int unsigned Scale = 61 - CoordBits;

  logic signed [W-1:0]  u_q   [Steps+1];
  logic signed [W-1:0]  v_q   [Steps+1];
  logic        [AccW-1:0] acc_q [Steps+1];

  logic signed [W-1:0] xs, ys, nu;
  assign xs = $signed({{(W-CoordBits){x_i[CoordBits-1]}}, x_i}) <<< Scale;
  assign ys = $signed({{(W-CoordBits){y_i[CoordBits-1]}}, y_i}) <<< Scale;
  assign nu = -xs;

  // half-turn pre-rotation brings the vector into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nu < 0) begin
        u_q[0]   <= xs;
        v_q[0]   <= ys;
        acc_q[0] <= {1'b1, {(AccW-1){1'b0}}};
      end else begin
        u_q[0]   <= nu;
        v_q[0]   <= -ys;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [W-1:0] du, dv;
    assign du = v_q[i] >>> i;
    assign dv = u_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[i] == '0) begin
          u_q[i+1]   <= u_q[i];
          v_q[i+1]   <= v_q[i];
          acc_q[i+1] <= acc_q[i];
        end else if (v_q[i] >= 0) begin
          u_q[i+1]   <= u_q[i] + du;
          v_q[i+1]   <= v_q[i] - dv;
          acc_q[i+1] <= acc_q[i] + lpgb_pkg::atan_entry(i);
        end else begin
          u_q[i+1]   <= u_q[i] - du;
          v_q[i+1]   <= v_q[i] + dv;
          acc_q[i+1] <= acc_q[i] - lpgb_pkg::atan_entry(i);
        end
      end
    end
  end

  assign turn_o = acc_q[Steps][AccW-1 -: AngleBits];

endmodule

// ----- hw/rtl/lpgb_div.sv -----
// ----------------------------------------------------------------------------
// lpgb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lpgb_div #(
  parameter int unsigned NumBits  = lpgb_pkg::NUM_BITS,
  parameter int unsigned DenBits  = lpgb_pkg::LIMIT_BITS,
  parameter int unsigned QuotBits = lpgb_pkg::QUOT_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  output logic [QuotBits-1:0] quot_o
);

  localparam int unsigned RemW = (NumBits > DenBits + QuotBits) ? NumBits
                                                               : DenBits + QuotBits;

  logic [RemW-1:0]     rem_q  [1:QuotBits];
  logic [DenBits-1:0]  den_q  [1:QuotBits];
  logic [QuotBits-1:0] quot_q [1:QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic [RemW-1:0]     rem_in, dsh;
    logic [DenBits-1:0]  den_in;
    logic [QuotBits-1:0] quot_in;

    if (k == 0) begin : g_first
      assign rem_in  = RemW'(num_i);
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign den_in  = den_q[k];
      assign quot_in = quot_q[k];
    end

    assign dsh = RemW'(den_in) << (QuotBits - 1 - k);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den_in;
        if (rem_in >= dsh) begin
          rem_q[k+1]  <= rem_in - dsh;
          quot_q[k+1] <= {quot_in[QuotBits-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_in;
          quot_q[k+1] <= {quot_in[QuotBits-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quot_q[QuotBits];

endmodule

// ----- hw/rtl/lidar_polar_grid_binning.sv -----
// ----------------------------------------------------------------------------
// lidar_polar_grid_binning
// Places lidar points on a polar grid: range, sector and radial bin per point.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  cfg     | cfg_valid_i/cfg_ready_o, index, data      | in
//  in      | in_valid_i/in_ready_o, pos_x/y/z          | in
//  out     | out_valid_o/out_ready_i, grid, idx, range | out
//
// one point per cycle while the output is not stalled; the longer path sets the
// depth: the root pipeline plus the 11-stage bin divider, or the 30-step angle unit.
// the whole pipeline holds while a result waits and out_ready_i is low;
// in_ready_o is high whenever the output register is empty or being taken.
// reset clears the valid bits and loads the register defaults.
module lidar_polar_grid_binning #(
  parameter int unsigned COORD_BITS = lpgb_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS = lpgb_pkg::ANGLE_BITS_DEF,
  parameter int unsigned INDEX_BITS = lpgb_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lpgb_pkg::CFG_ADDR_BITS-1:0]   cfg_index_i,
  input  logic [lpgb_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_BITS-1:0]         pos_x_i,
  input  logic signed [COORD_BITS-1:0]         pos_y_i,
  input  logic signed [COORD_BITS-1:0]         pos_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 in_grid_o,
  output logic [INDEX_BITS-1:0]                sector_index_o,
  output logic [INDEX_BITS-1:0]                radial_bin_o,
  output logic [lpgb_pkg::RANGE_OUT_BITS-1:0]  range_mm_o,
  output logic signed [COORD_BITS-1:0]         height_mm_o
);

  localparam int unsigned LimW   = lpgb_pkg::LIMIT_BITS;
  localparam int unsigned CntW   = lpgb_pkg::COUNT_BITS;
  localparam int unsigned QW     = lpgb_pkg::QUOT_BITS;
  localparam int unsigned NumW   = lpgb_pkg::NUM_BITS;
  localparam int unsigned SqW    = 2 * COORD_BITS;
  localparam int unsigned ProdW  = ANGLE_BITS + CntW;
  localparam int unsigned CmpW   = (COORD_BITS > LimW) ? COORD_BITS : LimW;
  localparam int unsigned GridSt = COORD_BITS + 3;
  localparam int unsigned LatR   = GridSt + QW;
  localparam int unsigned LatA   = lpgb_pkg::CORDIC_STEPS + 2;
  localparam int unsigned LatM   = (LatR > LatA) ? LatR : LatA;

  // configuration registers
  logic [LimW-1:0] rmin_q, rmax_q;
  logic [CntW-1:0] bins_q, secs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= lpgb_pkg::RANGE_MIN_RST;
      rmax_q <= lpgb_pkg::RANGE_MAX_RST;
      bins_q <= lpgb_pkg::BIN_COUNT_RST;
      secs_q <= lpgb_pkg::SECTOR_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (lpgb_pkg::cfg_reg_e'(cfg_index_i))
        lpgb_pkg::CfgRangeMin:    rmin_q <= cfg_data_i;
        lpgb_pkg::CfgRangeMax:    rmax_q <= cfg_data_i;
        lpgb_pkg::CfgBinCount:    bins_q <= cfg_data_i[CntW-1:0];
        lpgb_pkg::CfgSectorCount: secs_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic            en;
  logic            out_valid_q;
  logic [LatM-1:0] vld_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LatM-2:0], in_valid_i};
      out_valid_q <= vld_q[LatM-1];
    end
  end

  // range path: squares, sum, root
  logic [COORD_BITS-1:0]   ax, ay;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q, sum_q;
  logic [COORD_BITS-1:0]   root;

  assign ax = pos_x_i[COORD_BITS-1] ? COORD_BITS'(-pos_x_i) : pos_x_i;
  assign ay = pos_y_i[COORD_BITS-1] ? COORD_BITS'(-pos_y_i) : pos_y_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= SqW'(ax) * SqW'(ax);
      sqy_q <= SqW'(ay) * SqW'(ay);
      sum_q <= sqx_q + sqy_q;
    end
  end

  lpgb_isqrt #(
    .RootBits(COORD_BITS)
  ) u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (sum_q),
    .root_o(root)
  );

  // grid test and bin numerator
  logic [CmpW-1:0]              range_c, diff;
  logic                         grid_q;
  logic [COORD_BITS-1:0]        range_q;
  logic [lpgb_pkg::NUM_BITS-1:0] num_q;
  logic [LimW-1:0]              span_q;
  logic                         grid_hit;

  assign range_c  = CmpW'(root);
  assign diff     = range_c - CmpW'(rmin_q);
  assign grid_hit = (CmpW'(rmin_q) < range_c) && (range_c < CmpW'(rmax_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      grid_q  <= grid_hit;
      range_q <= root;
      span_q  <= rmax_q - rmin_q;
      num_q   <= grid_hit ? NumW'(diff[LimW-1:0]) * NumW'(bins_q) : '0;
    end
  end

  logic [QW-1:0] quot, quot_d;

  lpgb_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (span_q),
    .quot_o(quot)
  );

  lpgb_delay #(.Width(QW), .Depth(LatM - LatR)) u_dly_quot (
    .clk_i(clk_i), .en_i(en), .d_i(quot), .q_o(quot_d)
  );

  logic                  grid_d;
  logic [COORD_BITS-1:0] range_d;

  lpgb_delay #(.Width(COORD_BITS + 1), .Depth(LatM - GridSt)) u_dly_range (
    .clk_i(clk_i), .en_i(en), .d_i({grid_q, range_q}), .q_o({grid_d, range_d})
  );

  // angle path
  logic [ANGLE_BITS-1:0]      turn;
  logic [CntW-1:0]            sec_raw_q, sec_raw_d;
  logic [ANGLE_BITS+CntW-1:0] sec_prod;

  lpgb_cordic #(
    .CoordBits(COORD_BITS),
    .AngleBits(ANGLE_BITS)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (pos_x_i),
    .y_i   (pos_y_i),
    .turn_o(turn)
  );

  assign sec_prod = ProdW'(turn) * ProdW'(secs_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec_raw_q <= sec_prod[ANGLE_BITS+CntW-1:ANGLE_BITS];
    end
  end

  lpgb_delay #(.Width(CntW), .Depth(LatM - LatA)) u_dly_sec (
    .clk_i(clk_i), .en_i(en), .d_i(sec_raw_q), .q_o(sec_raw_d)
  );

  logic signed [COORD_BITS-1:0] height_d;

  lpgb_delay #(.Width(COORD_BITS), .Depth(LatM)) u_dly_height (
    .clk_i(clk_i), .en_i(en), .d_i(pos_z_i), .q_o(height_d)
  );

  // output register
  logic [INDEX_BITS-1:0] sec_idx, bin_idx;

  // a full turn wraps back to sector zero
  assign sec_idx = (!grid_d || sec_raw_d == secs_q) ? '0 : INDEX_BITS'(sec_raw_d);
  assign bin_idx = grid_d ? INDEX_BITS'(quot_d) : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_grid_o      <= grid_d;
      sector_index_o <= sec_idx;
      radial_bin_o   <= bin_idx;
      range_mm_o     <= lpgb_pkg::RANGE_OUT_BITS'(range_d);
      height_mm_o    <= height_d;
    end
  end

endmodule

// ----- hw/rtl/lpgb_checker.sv -----
// ----------------------------------------------------------------------------
// lpgb_checker
// Port-level checks for the polar grid binning block.
// ----------------------------------------------------------------------------
module lpgb_checker #(
  parameter int unsigned INDEX_BITS = lpgb_pkg::INDEX_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                in_grid_o,
  input logic [INDEX_BITS-1:0]               sector_index_o,
  input logic [INDEX_BITS-1:0]               radial_bin_o,
  input logic [lpgb_pkg::RANGE_OUT_BITS-1:0] range_mm_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_mm_o)
      && $stable(sector_index_o) && $stable(radial_bin_o))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input stalled with room at the output");

  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_grid_o |-> sector_index_o == '0 && radial_bin_o == '0)
    else $error("index nonzero outside grid");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_grid_o |-> range_mm_o != '0)
    else $error("zero range marked in grid");

endmodule

bind lidar_polar_grid_binning lpgb_checker #(
  .INDEX_BITS(INDEX_BITS)
) u_lpgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .in_grid_o     (in_grid_o),
  .sector_index_o(sector_index_o),
  .radial_bin_o  (radial_bin_o),
  .range_mm_o    (range_mm_o)
);

// ----- sim/lidar_polar_grid_binning_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_polar_grid_binning_tb
// Streams points through the polar binning block under several register
// settings and flow-control patterns; each result is checked against a listed
// expected cell or a bit-exact predictor of range, CORDIC angle, sector and radial bin.
// ----------------------------------------------------------------------------
module lidar_polar_grid_binning_tb;

  localparam int CB         = 20;
  localparam int AB         = 16;
  localparam int IB         = 10;
  localparam int DRAIN_WAIT = 40;
  localparam int LIMIT      = 600000;
  localparam int PHASE_PTS  = 140;
  localparam logic [lpgb_pkg::CFG_ADDR_BITS-1:0] CFG_UNUSED_IDX = 3'd5;

  localparam logic [31:0] ATAN_TURN [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

  typedef struct packed {
    logic          grid;
    logic [IB-1:0] sector;
    logic [IB-1:0] bin;
    logic [19:0]   range;
    logic [CB-1:0] height;
  } cell_t;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    bit    typed;
    cell_t want;
  } point_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [lpgb_pkg::CFG_ADDR_BITS-1:0] cfg_index_i = '0;
  logic [lpgb_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic signed [CB-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic in_grid_o;
  logic [IB-1:0] sector_index_o, radial_bin_o;
  logic [lpgb_pkg::RANGE_OUT_BITS-1:0] range_mm_o;
  logic signed [CB-1:0] height_mm_o;

  lidar_polar_grid_binning u_top (.*);

  // predictor copy of the registers
  logic [19:0] lim_lo, lim_hi;
  logic [10:0] n_bins, n_sectors;

  cell_t cells_due[$];
  int    errors = 0;
  int    cycles = 0;
  int    gap_pct = 0, stall_pct = 0;
  int    hold_left = 0;
  bit    hold_req = 1'b0;

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [AB-1:0] heading_turn(longint x, longint y);
    longint u, v, du, dv;
    logic [31:0] acc;
    u = -x * (64'sd1 <<< (61 - CB));
    v = -y * (64'sd1 <<< (61 - CB));
    acc = '0;
    if (u < 0) begin
      u = -u;
      v = -v;
      acc = 32'h80000000;
    end
    for (int i = 0; i < 30; i++) begin
      if (v == 0) break;
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u += du; v -= dv; acc += ATAN_TURN[i];
      end else begin
        u -= du; v += dv; acc -= ATAN_TURN[i];
      end
    end
    return acc[31 -: AB];
  endfunction

  function automatic cell_t bin_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                      logic signed [CB-1:0] z);
    cell_t c;
    longint xs, ys;
    longint unsigned rng, sec, bn;
    xs = x;
    ys = y;
    rng = int_sqrt(longint'(xs * xs + ys * ys));
    c = '0;
    c.range = rng[19:0];
    c.height = z;
    if (lim_lo < rng && rng < lim_hi) begin
      c.grid = 1'b1;
      sec = (longint'(heading_turn(xs, ys)) * n_sectors) >> AB;
      if (sec == n_sectors) sec = 0;
      bn = ((rng - lim_lo) * n_bins) / (lim_hi - lim_lo);
      c.sector = sec[IB-1:0];
      c.bin = bn[IB-1:0];
    end
    return c;
  endfunction

  // result checker: sample at the falling edge, take effect at the next rise
  always @(negedge clk_i) begin
    cell_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        $error("unexpected result range=%0d", range_mm_o);
        errors++;
      end else begin
        w = cells_due.pop_front();
        if (in_grid_o !== w.grid) begin
          $error("in_grid exp %0d got %0d", w.grid, in_grid_o); errors++;
        end
        if (sector_index_o !== w.sector) begin
          $error("sector_index exp %0d got %0d", w.sector, sector_index_o); errors++;
        end
        if (radial_bin_o !== w.bin) begin
          $error("radial_bin exp %0d got %0d", w.bin, radial_bin_o); errors++;
        end
        if (range_mm_o !== w.range) begin
          $error("range_mm exp %0d got %0d", w.range, range_mm_o); errors++;
        end
        if (height_mm_o !== w.height) begin
          $error("height_mm exp %0d got %0d", $signed(w.height), height_mm_o); errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                            logic signed [CB-1:0] z, bit typed, cell_t want);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cells_due.insert(cells_due.size(), typed ? want : bin_point(x, y, z));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [lpgb_pkg::CFG_ADDR_BITS-1:0] idx, logic [19:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      lpgb_pkg::CfgRangeMin:    lim_lo = val;
      lpgb_pkg::CfgRangeMax:    lim_hi = val;
      lpgb_pkg::CfgBinCount:    n_bins = val[10:0];
      lpgb_pkg::CfgSectorCount: n_sectors = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [19:0] lo, logic [19:0] hi, logic [19:0] nb,
                          logic [19:0] ns);
    drain();
    reg_write(lpgb_pkg::CfgRangeMin, lo);
    reg_write(lpgb_pkg::CfgRangeMax, hi);
    reg_write(lpgb_pkg::CfgBinCount, nb);
    reg_write(lpgb_pkg::CfgSectorCount, ns);
    reg_write(CFG_UNUSED_IDX, 20'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] clip(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return CB'(v);
  endfunction

  task automatic random_point;
    logic signed [CB-1:0] x, y, z;
    longint r, xi, yi;
    z = CB'($urandom);
    case ($urandom_range(5))
      0: begin x = CB'($urandom); y = CB'($urandom); end
      1: begin
        x = $urandom_range(1) ? CB'($urandom_range(200000))
                              : CB'(-$urandom_range(200000));
        y = '0;
        if ($urandom_range(1)) begin y = x; x = '0; end
      end
      2: begin x = $signed(7'($urandom)); y = $signed(7'($urandom)); end
      default: begin
        // aim near the limits or anywhere between them
        case ($urandom_range(2))
          0: r = longint'(lim_lo) + $urandom_range(4) - 2;
          1: r = longint'(lim_hi) + $urandom_range(4) - 2;
          default: r = lim_lo + $urandom_range(lim_hi - lim_lo);
        endcase
        if (r < 0) r = 0;
        xi = longint'($urandom_range(2 * r)) - r;
        yi = int_sqrt(longint'(r * r - xi * xi));
        if ($urandom_range(1)) yi = -yi;
        x = clip(xi);
        y = clip(yi);
      end
    endcase
    send_point(x, y, z, 1'b0, '0);
  endtask

  point_row_t rows[$];

  initial begin
    lim_lo = lpgb_pkg::RANGE_MIN_RST;
    lim_hi = lpgb_pkg::RANGE_MAX_RST;
    n_bins = lpgb_pkg::BIN_COUNT_RST;
    n_sectors = lpgb_pkg::SECTOR_COUNT_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // origin, out of range, corner extremes, axes
    rows = '{
      '{0, 0, 20'sh7FFFF, 1, '{0, 0, 0, 0, 20'sh7FFFF}},
      '{0, 0, -20'sh80000, 1, '{0, 0, 0, 0, -20'sh80000}},
      '{2000, 0, 5, 1, '{0, 0, 0, 2000, 5}},
      '{3000, 0, 6, 1, '{0, 0, 0, 3000, 6}},
      '{100000, 0, 7, 1, '{0, 0, 0, 100000, 7}},
      '{-20'sh80000, -20'sh80000, 0, 1, '{0, 0, 0, 741455, 0}},
      '{20'sh7FFFF, 20'sh7FFFF, 1, 1, '{0, 0, 0, 741453, 1}},
      '{-10000, 0, 3, 1, '{1, 0, 8, 10000, 3}},
      '{3001, 0, 0, 0, '0},
      '{99999, 0, 0, 0, '0},
      '{0, 50000, 0, 0, '0},
      '{0, -50000, 0, 0, '0},
      '{50000, 0, 0, 0, '0},
      '{-50000, 1, 0, 0, '0},
      '{-50000, -1, 0, 0, '0},
      '{30000, 40000, 0, 0, '0},
      '{-30000, 40000, 0, 0, '0},
      '{-30000, -40000, 0, 0, '0},
      '{30000, -40000, 0, 0, '0},
      '{-70000, 2, -12, 0, '0}};
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_grid(0, 20'hFFFFF, 1024, 1024);
        1: set_grid(1000, 5000, 1, 1);
        2: set_grid(500, 501, 7, 9);
        3: set_grid(20'hFFFFF, 20'hFFFFF, 0, 0);
        4: set_grid(200, 800000, 20'hFFFFF, 20'hFFFFF);
        default: set_grid(20'($urandom_range(50000)), 20'(60000 + $urandom_range(600000)),
                          20'(1 + $urandom_range(1023)), 20'(1 + $urandom_range(1023)));
      endcase
      for (int k = 0; k < PHASE_PTS; k++) begin
        case (k / 35)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 46; stall_pct = 0;  end
          2: begin gap_pct = 0;  stall_pct = 46; end
          default: begin gap_pct = 33; stall_pct = 33; end
        endcase
        if (k == 5 && ph == 1) hold_req = 1'b1;
        if (k == 70 && ph == 2) drain();
        random_point();
      end
    end

    gap_pct = 0;
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
